// ===== design/aabb_frustum_cull_core_macros.svh =====
// ----------------------------------------------------------------------------
// aabb frustum cull core assertion macros
// shared property forms for the port-level checks of the cull core
// ----------------------------------------------------------------------------
`ifndef AABB_FRUSTUM_CULL_CORE_MACROS_SVH
`define AABB_FRUSTUM_CULL_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define AFC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cull core check failed (same cycle)");

// next-cycle implication, sampled on clk, off during reset
`define AFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cull core check failed (next cycle)");

`endif

// ===== design/afc_pkg.sv =====
// ----------------------------------------------------------------------------
// afc_pkg
// types and constants shared by the aabb frustum cull core
// ----------------------------------------------------------------------------
package afc_pkg;

    // item commands
    localparam logic [1:0] CMD_LOAD_PLANE    = 2'd0;
    localparam logic [1:0] CMD_BEGIN_CHUNK   = 2'd1;
    localparam logic [1:0] CMD_TEST_INSTANCE = 2'd2;
    localparam logic [1:0] CMD_NONE          = 2'd3;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam logic [CFG_INDEX_W-1:0] REG_CAMERA_CULL_ENABLE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CAMERA_X            = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CAMERA_Y            = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CAMERA_Z            = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CULL_RADIUS_SQUARED = 3'd4;

    // 20000.0 squared as unsigned q32.32
    localparam logic [63:0] RADIUS_SQ_RESET = 64'd1717986918400000000;

    // multiplier operands: 2*a +/- s or a camera offset, both fit 34 bits
    localparam int OP_W  = 34;
    // product and accumulator width, holds three products plus the offset term
    localparam int ACC_W = 2 * OP_W;
    // q16.16 distance is doubled and moved to q32.32
    localparam int DIST_SHIFT = 17;

    typedef struct packed {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic signed [31:0] offset;
    } afc_plane_t;

    typedef struct packed {
        logic issue;
        logic first;
        logic last;
        logic tail;
    } afc_mac_ctrl_t;

    typedef struct packed {
        logic done;
        logic tail;
    } afc_mac_stat_t;

endpackage

// ===== design/afc_item_if.sv =====
// ----------------------------------------------------------------------------
// afc_item_if
// input channel of the cull core: one command transaction per handshake
// ----------------------------------------------------------------------------
interface afc_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [2:0]         plane_index;
    logic signed [31:0] vec_a_x;
    logic signed [31:0] vec_a_y;
    logic signed [31:0] vec_a_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic signed [31:0] plane_offset;
    logic [15:0]        instance_tag;

    modport source (
        output valid, command, plane_index, vec_a_x, vec_a_y, vec_a_z,
               scale_x, scale_y, scale_z, plane_offset, instance_tag,
        input  ready
    );

    modport sink (
        input  valid, command, plane_index, vec_a_x, vec_a_y, vec_a_z,
               scale_x, scale_y, scale_z, plane_offset, instance_tag,
        output ready
    );
endinterface

// ===== design/afc_result_if.sv =====
// ----------------------------------------------------------------------------
// afc_result_if
// output channel of the cull core: tag of one visible instance per transaction
// ----------------------------------------------------------------------------
interface afc_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] visible_tag;

    modport source (
        output valid, visible_tag,
        input  ready
    );

    modport sink (
        input  valid, visible_tag,
        output ready
    );
endinterface

// ===== design/afc_plane_store.sv =====
// ----------------------------------------------------------------------------
// afc_plane_store
// frustum plane register file, cleared at reset, one write and one read port
// ----------------------------------------------------------------------------
module afc_plane_store #(
    parameter int NUM_PLANES = 6,
    parameter int PW         = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [PW-1:0]       wr_index,
    input  afc_pkg::afc_plane_t wr_data,
    input  logic [PW-1:0]       rd_index,
    output afc_pkg::afc_plane_t rd_data
);
    import afc_pkg::*;

    afc_plane_t entry_reg [NUM_PLANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            entry_reg[wr_index] <= wr_data;
        end
    end

    assign rd_data = entry_reg[rd_index];

endmodule

// ===== design/afc_mac.sv =====
// ----------------------------------------------------------------------------
// afc_mac
// shared multiply-accumulate unit: registered product, then wide accumulate
// ----------------------------------------------------------------------------
module afc_mac (
    input  logic                            clk,
    input  logic                            rst_n,
    input  afc_pkg::afc_mac_ctrl_t          ctrl,
    input  logic signed [afc_pkg::OP_W-1:0] op_a,
    input  logic signed [afc_pkg::OP_W-1:0] op_b,
    input  logic signed [afc_pkg::ACC_W-1:0] init,
    output logic signed [afc_pkg::ACC_W-1:0] acc,
    output afc_pkg::afc_mac_stat_t          stat
);
    import afc_pkg::*;

    afc_mac_ctrl_t           ctrl_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] init_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    afc_mac_stat_t           stat_reg;
    afc_mac_stat_t           stat_next;
    logic signed [ACC_W-1:0] prod_next;

    assign prod_next = op_a * op_b;

    // first product of a group starts from the init term
    always_comb
    begin
        acc_next       = (ctrl_reg.first ? init_reg : acc_reg) + prod_reg;
        stat_next.done = ctrl_reg.issue && ctrl_reg.last;
        stat_next.tail = ctrl_reg.issue && ctrl_reg.tail;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
            stat_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl;
            stat_reg <= stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        init_reg <= init;
        if (ctrl_reg.issue)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc  = acc_reg;
    assign stat = stat_reg;

endmodule

// ===== design/aabb_frustum_cull_core.sv =====
// ----------------------------------------------------------------------------
// aabb_frustum_cull_core
// frustum culling of axis-aligned instance boxes grouped into chunks
// ----------------------------------------------------------------------------
// One transaction on item carries a command. A plane load writes the plane
// store and leaves the core ready in the next cycle. A chunk begin with camera
// culling enabled squares the three center-to-camera offsets through the shared
// multiplier; with culling off it finishes at once. An instance test runs one
// multiply per axis per plane through the single multiply-accumulate unit,
// n * (2p + s) for a non-negative normal and n * (2p - s) for a negative one;
// an instance passes through the multiplier issue loop, the product and
// accumulate registers, and the hand-off of the tag to the output register.
// An instance of an out-of-range chunk is dropped in the cycle it is accepted.
// The output register lets the core take a new item while a visible tag still
// waits on result; a later visible tag waits for that register to empty.
// All math is exact fixed point at 68 bits, no rounding or saturation.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_core #(
    parameter int NUM_PLANES = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    afc_item_if.sink                          item,
    afc_result_if.source                      result,
    input  logic                              cfg_write,
    input  logic [afc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [afc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import afc_pkg::*;

    localparam int PW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam logic [PW-1:0] LAST_PLANE = PW'(NUM_PLANES - 1);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_HOLD  = 2'd3;

    // axis codes of the issue loop
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // configuration registers
    logic                    enable_reg;
    logic signed [31:0]      cam_x_reg;
    logic signed [31:0]      cam_y_reg;
    logic signed [31:0]      cam_z_reg;
    logic [63:0]             radius_reg;

    // sequencer and work registers
    logic [1:0]              state_reg,  state_next;
    logic [1:0]              k_reg,      k_next;
    logic [PW-1:0]           p_reg,      p_next;
    logic                    chunk_mode_reg, chunk_mode_next;
    logic                    in_range_reg,   in_range_next;
    logic                    culled_reg,     culled_next;
    logic [15:0]             tag_reg,        tag_next;
    logic signed [OP_W-1:0]  plus_reg  [3];
    logic signed [OP_W-1:0]  minus_reg [3];
    logic                    load_ops;
    logic                    out_valid_reg,  out_valid_next;
    logic [15:0]             out_tag_reg,    out_tag_next;

    // operand preparation at accept time
    logic signed [OP_W-1:0]  pos_x2 [3];
    logic signed [OP_W-1:0]  scl_ext [3];
    logic signed [OP_W-1:0]  cam_off [3];
    logic signed [OP_W-1:0]  plus_in [3];
    logic signed [OP_W-1:0]  minus_in [3];

    // plane store and shared unit hookup
    afc_plane_t              wr_plane;
    logic                    store_wr;
    afc_plane_t              cur_plane;
    logic signed [31:0]      normal;
    afc_mac_ctrl_t           mac_ctrl;
    logic signed [OP_W-1:0]  mac_a;
    logic signed [OP_W-1:0]  mac_b;
    logic signed [ACC_W-1:0] mac_init;
    logic signed [ACC_W-1:0] mac_acc;
    afc_mac_stat_t           mac_stat;

    logic                    accept;
    logic                    chunk_far;
    logic                    plane_neg;

    assign accept = item.valid && item.ready;
    assign item.ready = (state_reg == S_IDLE);

    // ------------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            cam_x_reg  <= '0;
            cam_y_reg  <= '0;
            cam_z_reg  <= '0;
            radius_reg <= RADIUS_SQ_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CAMERA_CULL_ENABLE:  enable_reg <= cfg_data[0];
                REG_CAMERA_X:            cam_x_reg  <= $signed(cfg_data[31:0]);
                REG_CAMERA_Y:            cam_y_reg  <= $signed(cfg_data[31:0]);
                REG_CAMERA_Z:            cam_z_reg  <= $signed(cfg_data[31:0]);
                REG_CULL_RADIUS_SQUARED: radius_reg <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // plane store
    // ------------------------------------------------------------------------
    assign wr_plane.nx     = item.vec_a_x;
    assign wr_plane.ny     = item.vec_a_y;
    assign wr_plane.nz     = item.vec_a_z;
    assign wr_plane.offset = item.plane_offset;

    // loads beyond the plane count are ignored
    assign store_wr = accept && (item.command == CMD_LOAD_PLANE)
                      && ({1'b0, item.plane_index} < 4'(NUM_PLANES));

    afc_plane_store #(
        .NUM_PLANES (NUM_PLANES),
        .PW         (PW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (store_wr),
        .wr_index (item.plane_index[PW-1:0]),
        .wr_data  (wr_plane),
        .rd_index (p_reg),
        .rd_data  (cur_plane)
    );

    // ------------------------------------------------------------------------
    // operands: 2*pos +/- scale for instances, center - camera for chunks
    // ------------------------------------------------------------------------
    always_comb
    begin
        pos_x2[0]  = {{(OP_W-33){item.vec_a_x[31]}}, item.vec_a_x, 1'b0};
        pos_x2[1]  = {{(OP_W-33){item.vec_a_y[31]}}, item.vec_a_y, 1'b0};
        pos_x2[2]  = {{(OP_W-33){item.vec_a_z[31]}}, item.vec_a_z, 1'b0};
        scl_ext[0] = {{(OP_W-32){item.scale_x[31]}}, item.scale_x};
        scl_ext[1] = {{(OP_W-32){item.scale_y[31]}}, item.scale_y};
        scl_ext[2] = {{(OP_W-32){item.scale_z[31]}}, item.scale_z};
        cam_off[0] = {{(OP_W-32){item.vec_a_x[31]}}, item.vec_a_x}
                     - {{(OP_W-32){cam_x_reg[31]}}, cam_x_reg};
        cam_off[1] = {{(OP_W-32){item.vec_a_y[31]}}, item.vec_a_y}
                     - {{(OP_W-32){cam_y_reg[31]}}, cam_y_reg};
        cam_off[2] = {{(OP_W-32){item.vec_a_z[31]}}, item.vec_a_z}
                     - {{(OP_W-32){cam_z_reg[31]}}, cam_z_reg};
        for (int i = 0; i < 3; i++)
        begin
            if (item.command == CMD_BEGIN_CHUNK)
            begin
                plus_in[i]  = cam_off[i];
                minus_in[i] = cam_off[i];
            end
            else
            begin
                plus_in[i]  = pos_x2[i] + scl_ext[i];
                minus_in[i] = pos_x2[i] - scl_ext[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ops)
        begin
            for (int i = 0; i < 3; i++)
            begin
                plus_reg[i]  <= plus_in[i];
                minus_reg[i] <= minus_in[i];
            end
        end
    end

    // ------------------------------------------------------------------------
    // shared multiply-accumulate issue
    // ------------------------------------------------------------------------
    always_comb
    begin
        case (k_reg)
            AXIS_X:  normal = cur_plane.nx;
            AXIS_Y:  normal = cur_plane.ny;
            AXIS_Z:  normal = cur_plane.nz;
            default: normal = cur_plane.nz;
        endcase
    end

    always_comb
    begin
        mac_ctrl.issue = (state_reg == S_ISSUE);
        mac_ctrl.first = (k_reg == AXIS_X);
        mac_ctrl.last  = (k_reg == AXIS_Z);
        mac_ctrl.tail  = (k_reg == AXIS_Z) && (chunk_mode_reg || (p_reg == LAST_PLANE));
        if (chunk_mode_reg)
        begin
            // squared offset, sum starts at zero
            mac_a    = plus_reg[k_reg];
            mac_b    = plus_reg[k_reg];
            mac_init = '0;
        end
        else
        begin
            // |n| * s folded in by the sign of the normal
            mac_a    = {{(OP_W-32){normal[31]}}, normal};
            mac_b    = normal[31] ? minus_reg[k_reg] : plus_reg[k_reg];
            mac_init = {{(ACC_W-32-DIST_SHIFT){cur_plane.offset[31]}}, cur_plane.offset,
                        {DIST_SHIFT{1'b0}}};
        end
    end

    afc_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .op_a  (mac_a),
        .op_b  (mac_b),
        .init  (mac_init),
        .acc   (mac_acc),
        .stat  (mac_stat)
    );

    // chunk sum is never negative, so an unsigned compare is exact
    assign chunk_far = mac_acc > {{(ACC_W-64){1'b0}}, radius_reg};
    assign plane_neg = mac_acc[ACC_W-1];

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        p_next          = p_reg;
        chunk_mode_next = chunk_mode_reg;
        in_range_next   = in_range_reg;
        culled_next     = culled_reg;
        tag_next        = tag_reg;
        load_ops        = 1'b0;
        out_valid_next  = out_valid_reg && !result.ready;
        out_tag_next    = out_tag_reg;

        // a plane result lands while later planes still issue
        if (mac_stat.done && !chunk_mode_reg && plane_neg)
        begin
            culled_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (item.command)
                        CMD_BEGIN_CHUNK:
                        begin
                            if (enable_reg)
                            begin
                                load_ops        = 1'b1;
                                chunk_mode_next = 1'b1;
                                k_next          = AXIS_X;
                                state_next      = S_ISSUE;
                            end
                            else
                            begin
                                in_range_next = 1'b1;
                            end
                        end
                        CMD_TEST_INSTANCE:
                        begin
                            if (in_range_reg)
                            begin
                                load_ops        = 1'b1;
                                chunk_mode_next = 1'b0;
                                k_next          = AXIS_X;
                                p_next          = '0;
                                culled_next     = 1'b0;
                                tag_next        = item.instance_tag;
                                state_next      = S_ISSUE;
                            end
                        end
                        default:
                        begin
                            // plane loads go straight to the store
                        end
                    endcase
                end
            end
            S_ISSUE:
            begin
                if (k_reg == AXIS_Z)
                begin
                    k_next = AXIS_X;
                    if (mac_ctrl.tail)
                    begin
                        state_next = S_WAIT;
                    end
                    else
                    begin
                        p_next = p_reg + PW'(1);
                    end
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            S_WAIT:
            begin
                if (mac_stat.done && mac_stat.tail)
                begin
                    if (chunk_mode_reg)
                    begin
                        in_range_next = !chunk_far;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                if (culled_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_tag_next   = tag_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            k_reg          <= AXIS_X;
            p_reg          <= '0;
            chunk_mode_reg <= 1'b0;
            in_range_reg   <= 1'b1;
            culled_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            p_reg          <= p_next;
            chunk_mode_reg <= chunk_mode_next;
            in_range_reg   <= in_range_next;
            culled_reg     <= culled_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg     <= tag_next;
        out_tag_reg <= out_tag_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.visible_tag = out_tag_reg;

endmodule

// ===== design/afc_checker.sv =====
// ----------------------------------------------------------------------------
// afc_checker
// port-level checks of the cull core, bound to the top level
// ----------------------------------------------------------------------------
`include "aabb_frustum_cull_core_macros.svh"

module afc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input logic [1:0]  item_command,
    input logic        result_valid,
    input logic        result_ready,
    input logic [15:0] result_tag
);
    import afc_pkg::*;

    logic result_stall;
    logic quick_item;

    assign result_stall = result_valid && !result_ready;
    // plane loads and unused commands taken this cycle
    assign quick_item   = item_valid && item_ready
                          && (item_command == CMD_LOAD_PLANE || item_command == CMD_NONE);

    // a waiting tag stays put until taken
    `AFC_ASSERT_NEXT(a_result_hold, result_stall, result_valid && $stable(result_tag))

    // a new tag only shows up right after a busy stretch
    `AFC_ASSERT_SAME(a_result_after_busy, $rose(result_valid), $past(!item_ready))

    // plane loads and unused commands never stall the input
    `AFC_ASSERT_NEXT(a_load_no_stall, quick_item, item_ready)

endmodule

bind aabb_frustum_cull_core afc_checker u_afc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_command (item.command),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_tag   (result.visible_tag)
);
